// ----- rtl/core/heat_index_polynomial_top_macros.svh -----
// Assertion macros used by the heat index port checker.
`ifndef HEAT_INDEX_POLYNOMIAL_TOP_MACROS_SVH
`define HEAT_INDEX_POLYNOMIAL_TOP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define HIP_ASSERT_NOW(lbl, clk_i, rstn_i, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |-> (cons)) \
		else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define HIP_ASSERT_NEXT(lbl, clk_i, rstn_i, ante, cons, msg) \
	lbl: assert property (@(posedge clk_i) disable iff (!rstn_i) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/hip_pkg.sv -----
// Types, constants and coefficient helpers for the heat index polynomial.
package hip_pkg;

	localparam int HIP_COEF_FRAC_BITS = 48;
	localparam int HIP_IN_FRAC_BITS   = 4;
	// Integer bits kept above the fraction of the widest sum, with margin.
	localparam int HIP_HEAD_BITS      = 40;
	localparam int HIP_DATA_W = HIP_COEF_FRAC_BITS + 6 * HIP_IN_FRAC_BITS + HIP_HEAD_BITS;

	localparam int HIP_T_W        = 13;
	localparam int HIP_H_W        = 11;
	localparam int HIP_OUT_W      = 16;
	localparam int HIP_S_TDATA_W  = 24;
	localparam int HIP_PIPE_DEPTH = 14;

	localparam logic [HIP_OUT_W-1:0] HIP_HI_MAX = 16'h7fff;
	localparam logic [HIP_OUT_W-1:0] HIP_HI_MIN = 16'h8000;

	// Wide enough for any scaled coefficient at the largest fraction width.
	localparam int HIP_KW = 160;

	// Terms indexed by 4 * (power of t) + (power of h); |c| = mant / 10^dexp.
	localparam logic [19:0] HIP_MANT [16] = '{
		20'd16923,  20'd537941, 20'd728898, 20'd291583,
		20'd185212, 20'd100254, 20'd814971, 20'd197483,
		20'd941695, 20'd345372, 20'd102102, 20'd843296,
		20'd38646,  20'd142721, 20'd218429, 20'd481975
	};
	localparam logic [4:0] HIP_DEXP [16] = '{
		5'd3,  5'd5,  5'd8,  5'd10,
		5'd6,  5'd6,  5'd9,  5'd12,
		5'd8,  5'd9,  5'd10, 5'd15,
		5'd9,  5'd11, 5'd13, 5'd16
	};
	localparam logic [15:0] HIP_NEG = 16'b1101_0000_0110_0000;

	typedef struct packed {
		logic ld_a;
		logic ld_b;
	} hip_step_en_t;

	// Signed coefficient, round half up of |c| * 2^cf, in two's complement.
	function automatic logic [HIP_KW-1:0] hip_coef(input logic [3:0] idx, input int cf);
		logic [HIP_KW-1:0] k;
		logic [HIP_KW-1:0] p;
		int e;
		k = HIP_KW'(HIP_MANT[idx]) << (cf + 1);
		p = HIP_KW'(1);
		for (e = 0; e < 16; e++) begin
			if (e < int'(HIP_DEXP[idx])) p = p * HIP_KW'(10);
		end
		k = k + p;
		for (e = 0; e < 16; e++) begin
			if (e < int'(HIP_DEXP[idx])) k = k / 10;
		end
		k = k >> 1;
		if (HIP_NEG[idx]) k = -k;
		return k;
	endfunction

endpackage

// ----- rtl/core/hip_horner_step.sv -----
// One Horner step y = x * m + add over two register stages, modulo 2^W.
module hip_horner_step import hip_pkg::*; #(
	parameter int W       = HIP_DATA_W,
	parameter int MW      = HIP_H_W,
	parameter bit MSIGN   = 1'b0
) (
	input  logic         clk,
	input  hip_step_en_t en,
	input  logic [W-1:0] x,
	input  logic [MW-1:0] m,
	input  logic [W-1:0] add,
	output logic [W-1:0] y
);

	localparam int NS  = (W + 31) / 32;
	localparam int PW  = NS * 32;
	localparam int PPW = 32 + MW;

	logic [PW-1:0]    x_pad;
	logic [PW+31:0]   ev_w;
	logic [PW+31:0]   od_w;
	logic [PPW-1:0]   pp [NS];
	logic [W-1:0]     corr;

	logic [W-1:0] ev_s1;
	logic [W-1:0] od_s1;
	logic [W-1:0] add_s1;
	logic [W-1:0] corr_s1;
	logic [W-1:0] y_s2;

	// Products of 32-bit slices; slices of equal parity never overlap, so each
	// parity group is just a concatenation.
	always_comb begin
		x_pad = PW'(x);
		ev_w  = '0;
		od_w  = '0;
		for (int k = 0; k < NS; k++) begin
			pp[k] = PPW'(x_pad[32*k +: 32]) * PPW'(m);
			if ((k & 1) == 0) begin
				ev_w[32*k +: PPW] = pp[k];
			end else begin
				od_w[32*k +: PPW] = pp[k];
			end
		end
	end

	// A negative multiplier was taken as unsigned, which adds x * 2^MW too much.
	assign corr = (MSIGN && m[MW-1]) ? (x << MW) : '0;

	always_ff @(posedge clk) begin
		if (en.ld_a) begin
			ev_s1   <= ev_w[W-1:0];
			od_s1   <= od_w[W-1:0];
			add_s1  <= add;
			corr_s1 <= corr;
		end
		if (en.ld_b) begin
			y_s2 <= ev_s1 + od_s1 + add_s1 - corr_s1;
		end
	end

	assign y = y_s2;

endmodule

// ----- rtl/core/heat_index_polynomial_top.sv -----
// Top level of the pipelined sixteen-term heat index polynomial evaluator.
//
//   channel  direction  tdata                                       tuser
//   s_*      in         [12:0] temperature, [23:13] humidity        -
//   m_*      out        [15:0] heat_index                           [0] saturated
//
// One item is taken per cycle while the input is not held off, as described below.
// The depth is six Horner steps of two stages each plus rounding and saturation.
// Reset clears only the stage valid bits; the data path registers are not reset.
// A stalled output holds; upstream stages keep filling bubbles, so the input
// is held off only when all 14 stages hold an item.
module heat_index_polynomial_top import hip_pkg::*; #(
	parameter int COEF_FRAC_BITS = HIP_COEF_FRAC_BITS,
	parameter int IN_FRAC_BITS   = HIP_IN_FRAC_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     s_tvalid,
	output logic                     s_tready,
	input  logic [HIP_S_TDATA_W-1:0] s_tdata,   // [12:0] temperature, [23:13] humidity
	output logic                     m_tvalid,
	input  logic                     m_tready,
	output logic [HIP_OUT_W-1:0]     m_tdata,   // [15:0] heat_index
	output logic [0:0]               m_tuser    // [0] saturated
);

	localparam int W  = COEF_FRAC_BITS + 6 * IN_FRAC_BITS + HIP_HEAD_BITS;
	localparam int D  = COEF_FRAC_BITS + 6 * IN_FRAC_BITS - 4;
	localparam int QW = W - D;
	localparam logic [W-1:0] RND_BIAS = W'(1) << (D - 1);
	localparam int ND = HIP_PIPE_DEPTH;

	logic [ND:1] vld_s;
	logic [ND:1] en;
	logic [ND:1] vld_in;
	hip_step_en_t step_en [6];

	logic [HIP_T_W-1:0] temp_in;
	logic [HIP_H_W-1:0] hum_in;
	logic [HIP_T_W-1:0] temp_s [1:10];
	logic [HIP_H_W-1:0] hum_s [1:4];

	logic [W-1:0] hy1 [4];
	logic [W-1:0] hy2 [4];
	logic [W-1:0] q   [4];
	logic [W-1:0] q1_s [7:8];
	logic [W-1:0] q0_s [7:10];
	logic [W-1:0] ty1;
	logic [W-1:0] ty2;
	logic [W-1:0] sum;
	logic [W-1:0] rnd_s13;

	logic [QW-1:0]        quo;
	logic                 fits;
	logic [HIP_OUT_W-1:0] hi_nxt;
	logic [HIP_OUT_W-1:0] hi_s14;
	logic                 sat_s14;

	assign temp_in = s_tdata[HIP_T_W-1:0];
	assign hum_in  = s_tdata[HIP_T_W +: HIP_H_W];

	// A stage may load when the output is taken or any stage from it to the last is empty.
	for (genvar k = 1; k <= ND; k++) begin : g_en
		assign en[k] = m_tready | ~(&vld_s[ND:k]);
	end

	for (genvar s = 0; s < 6; s++) begin : g_step_en
		assign step_en[s].ld_a = en[2*s+1];
		assign step_en[s].ld_b = en[2*s+2];
	end

	assign vld_in = {vld_s[ND-1:1], s_tvalid};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			vld_s <= (en & vld_in) | (~en & vld_s);
		end
	end

	always_ff @(posedge clk) begin
		if (en[1]) temp_s[1] <= temp_in;
		for (int k = 2; k <= 10; k++) begin
			if (en[k]) temp_s[k] <= temp_s[k-1];
		end
		if (en[1]) hum_s[1] <= hum_in;
		for (int k = 2; k <= 4; k++) begin
			if (en[k]) hum_s[k] <= hum_s[k-1];
		end
	end

	// Lane i evaluates the humidity polynomial that multiplies t^i.
	for (genvar i = 0; i < 4; i++) begin : g_lane
		localparam logic [W-1:0] K3 = W'(hip_coef(4'(4*i+3), COEF_FRAC_BITS));
		localparam logic [W-1:0] A2 =
			W'(hip_coef(4'(4*i+2), COEF_FRAC_BITS) << IN_FRAC_BITS);
		localparam logic [W-1:0] A1 =
			W'(hip_coef(4'(4*i+1), COEF_FRAC_BITS) << (2 * IN_FRAC_BITS));
		localparam logic [W-1:0] A0 =
			W'(hip_coef(4'(4*i), COEF_FRAC_BITS) << (3 * IN_FRAC_BITS));

		hip_horner_step #(.W(W), .MW(HIP_H_W), .MSIGN(1'b0)) u_h1 (
			.clk (clk),
			.en  (step_en[0]),
			.x   (K3),
			.m   (hum_in),
			.add (A2),
			.y   (hy1[i])
		);

		hip_horner_step #(.W(W), .MW(HIP_H_W), .MSIGN(1'b0)) u_h2 (
			.clk (clk),
			.en  (step_en[1]),
			.x   (hy1[i]),
			.m   (hum_s[2]),
			.add (A1),
			.y   (hy2[i])
		);

		hip_horner_step #(.W(W), .MW(HIP_H_W), .MSIGN(1'b0)) u_h3 (
			.clk (clk),
			.en  (step_en[2]),
			.x   (hy2[i]),
			.m   (hum_s[4]),
			.add (A0),
			.y   (q[i])
		);
	end

	// The lower lanes wait, already scaled, for the temperature step that uses them.
	always_ff @(posedge clk) begin
		if (en[7]) q1_s[7] <= q[1] << (2 * IN_FRAC_BITS);
		if (en[8]) q1_s[8] <= q1_s[7];
		if (en[7]) q0_s[7] <= q[0] << (3 * IN_FRAC_BITS);
		for (int k = 8; k <= 10; k++) begin
			if (en[k]) q0_s[k] <= q0_s[k-1];
		end
	end

	hip_horner_step #(.W(W), .MW(HIP_T_W), .MSIGN(1'b1)) u_t1 (
		.clk (clk),
		.en  (step_en[3]),
		.x   (q[3]),
		.m   (temp_s[6]),
		.add (q[2] << IN_FRAC_BITS),
		.y   (ty1)
	);

	hip_horner_step #(.W(W), .MW(HIP_T_W), .MSIGN(1'b1)) u_t2 (
		.clk (clk),
		.en  (step_en[4]),
		.x   (ty1),
		.m   (temp_s[8]),
		.add (q1_s[8]),
		.y   (ty2)
	);

	hip_horner_step #(.W(W), .MW(HIP_T_W), .MSIGN(1'b1)) u_t3 (
		.clk (clk),
		.en  (step_en[5]),
		.x   (ty2),
		.m   (temp_s[10]),
		.add (q0_s[10]),
		.y   (sum)
	);

	// Round half up, then the arithmetic shift is just the upper bits.
	assign quo  = rnd_s13[W-1:D];
	assign fits = (&quo[QW-1:HIP_OUT_W-1]) | ~(|quo[QW-1:HIP_OUT_W-1]);

	always_comb begin
		if (fits) begin
			hi_nxt = quo[HIP_OUT_W-1:0];
		end else if (quo[QW-1]) begin
			hi_nxt = HIP_HI_MIN;
		end else begin
			hi_nxt = HIP_HI_MAX;
		end
	end

	always_ff @(posedge clk) begin
		if (en[13]) rnd_s13 <= sum + RND_BIAS;
		if (en[14]) begin
			hi_s14  <= hi_nxt;
			sat_s14 <= ~fits;
		end
	end

	assign s_tready   = en[1];
	assign m_tvalid   = vld_s[ND];
	assign m_tdata    = hi_s14;
	assign m_tuser[0] = sat_s14;

endmodule

// ----- rtl/core/hip_port_chk.sv -----
// Port-level checker for the heat index evaluator, bound to the top level.
`include "heat_index_polynomial_top_macros.svh"

module hip_port_chk import hip_pkg::*; (
	input logic                     clk,
	input logic                     arst_n,
	input logic                     s_tvalid,
	input logic                     s_tready,
	input logic                     m_tvalid,
	input logic                     m_tready,
	input logic [HIP_OUT_W-1:0]     m_tdata,
	input logic [0:0]               m_tuser
);

	localparam int OW = $clog2(HIP_PIPE_DEPTH + 1);

	logic [OW-1:0] occ_q;
	logic          in_acc;
	logic          out_acc;

	assign in_acc  = s_tvalid & s_tready;
	assign out_acc = m_tvalid & m_tready;

	// Items accepted whose results have not yet been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else begin
			occ_q <= occ_q + OW'(in_acc) - OW'(out_acc);
		end
	end

	`HIP_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata) && $stable(m_tuser), "output item changed while stalled")

	`HIP_ASSERT_NOW(a_sat_limit, clk, arst_n, m_tvalid && m_tuser[0],
		m_tdata == HIP_HI_MAX || m_tdata == HIP_HI_MIN, "saturated item not at a limit")

	`HIP_ASSERT_NOW(a_full_stall, clk, arst_n, !s_tready,
		occ_q == OW'(HIP_PIPE_DEPTH) && !m_tready, "input held off with room in pipeline")

	`HIP_ASSERT_NOW(a_empty_idle, clk, arst_n, occ_q == '0,
		!m_tvalid, "result shown with no item in flight")

endmodule

bind heat_index_polynomial_top hip_port_chk u_hip_port_chk (.*);

// ----- dv/heat_index_polynomial_top_tb.sv -----
// Self-checking stream testbench for the heat index polynomial evaluator.
`timescale 1ns / 100ps

module heat_index_polynomial_top_tb import hip_pkg::*; ();

	localparam int COEF_FRAC   = 48;
	localparam int IN_FRAC     = 4;
	localparam int ACC_W       = 160;
	localparam int ROUND_SHIFT = COEF_FRAC + 6 * IN_FRAC - 4;
	localparam int RANDOM_ITEMS = 1334;
	localparam int STEADY_TAIL  = 200;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 30;

	typedef logic signed [ACC_W-1:0] acc_t;

	typedef struct packed {
		logic signed [15:0] hi;
		logic               sat;
	} hi_reading_t;

	typedef struct packed {
		logic signed [12:0] temp;
		logic [10:0]        hum;
		logic               typed;
		logic signed [15:0] hi;
		logic               sat;
	} stim_row_t;

	// Sixteen terms: |c| = mant / 10^dexp, sign, power of t, power of rh.
	localparam int TERM_MANT [16] = '{16923, 185212, 537941, 100254, 941695, 728898,
		345372, 814971, 102102, 38646, 291583, 142721, 197483, 218429, 843296, 481975};
	localparam int TERM_DEXP [16] = '{3, 6, 5, 6, 8, 8, 9, 9, 10, 9, 10, 11, 12, 13, 15, 16};
	localparam bit TERM_NEG [16] = '{0, 0, 0, 1, 0, 0, 0, 1, 0, 1, 0, 0, 0, 1, 0, 1};
	localparam int TERM_TP [16] = '{0, 1, 0, 1, 2, 0, 2, 1, 2, 3, 0, 3, 1, 3, 2, 3};
	localparam int TERM_HP [16] = '{0, 0, 1, 1, 0, 2, 1, 2, 2, 0, 3, 1, 3, 2, 3, 3};

	localparam int T_EDGES [6] = '{-4096, -640, -1, 0, 2560, 4095};
	localparam int H_EDGES [5] = '{0, 1, 1600, 1601, 2047};

	// Corners of both fields, the nominal range limits and points outside it.
	localparam stim_row_t DIRECTED [16] = '{
		'{0, 0, 1, 271, 0},
		'{4095, 2047, 1, 32767, 1},
		'{-4096, 2047, 1, 32767, 1},
		'{-4096, 0, 0, 0, 0},
		'{4095, 0, 0, 0, 0},
		'{0, 2047, 0, 0, 0},
		'{-640, 0, 0, 0, 0},
		'{-640, 1600, 0, 0, 0},
		'{2560, 1600, 0, 0, 0},
		'{2560, 0, 0, 0, 0},
		'{1440, 640, 0, 0, 0},
		'{1600, 960, 0, 0, 0},
		'{-1, 1, 0, 0, 0},
		'{1, 2047, 0, 0, 0},
		'{-640, 2047, 0, 0, 0},
		'{-2048, 1600, 0, 0, 0}
	};

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     s_tvalid = 1'b0;
	logic                     s_tready;
	logic [HIP_S_TDATA_W-1:0] s_tdata = '0;
	logic                     m_tvalid;
	logic                     m_tready = 1'b0;
	logic [HIP_OUT_W-1:0]     m_tdata;
	logic [0:0]               m_tuser;

	acc_t        coef_k [16];
	hi_reading_t expected_readings [$];
	int          mismatch_count = 0;
	int          results_checked = 0;
	int          saturated_seen = 0;
	int          samples_sent = 0;
	int          cycle_count = 0;
	bit          steady_tail = 1'b0;

	heat_index_polynomial_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Coefficient magnitude rounded half up at COEF_FRAC fraction bits.
	function automatic acc_t scaled_coef(input int mant, input int dexp, input bit neg);
		acc_t k;
		acc_t p10;
		int e;
		k = acc_t'(mant) <<< (COEF_FRAC + 1);
		p10 = acc_t'(1);
		for (e = 0; e < dexp; e++) p10 = p10 * acc_t'(10);
		k = (k + p10) / p10;
		k = k >>> 1;
		return neg ? -k : k;
	endfunction

	// Exact sum of all terms, then round half up to 1/16 F and saturate.
	function automatic hi_reading_t heat_index_of(input logic signed [12:0] t,
			input logic [10:0] h);
		acc_t tv;
		acc_t hv;
		acc_t part;
		acc_t total;
		hi_reading_t r;
		int n;
		int p;
		tv = t;
		hv = h;
		total = '0;
		for (n = 0; n < 16; n++) begin
			part = coef_k[n];
			for (p = 0; p < TERM_TP[n]; p++) part = part * tv;
			for (p = 0; p < TERM_HP[n]; p++) part = part * hv;
			part = part <<< (IN_FRAC * (6 - TERM_TP[n] - TERM_HP[n]));
			total = total + part;
		end
		total = total + (acc_t'(1) <<< (ROUND_SHIFT - 1));
		total = total >>> ROUND_SHIFT;
		if (total > acc_t'(32767)) begin
			r.hi = 16'sh7fff;
			r.sat = 1'b1;
		end else if (total < acc_t'(-32768)) begin
			r.hi = 16'sh8000;
			r.sat = 1'b1;
		end else begin
			r.hi = total[15:0];
			r.sat = 1'b0;
		end
		return r;
	endfunction

	task automatic note_mismatch(input string what, input int got, input int want);
		$display("MISMATCH %s: got %0d, expected %0d (result %0d, cycle %0d)",
			what, got, want, results_checked, cycle_count);
		mismatch_count++;
	endtask

	// Offers one item and queues its expected reading once it is taken.
	task automatic send_sample(input logic signed [12:0] t, input logic [10:0] h,
			input hi_reading_t want);
		s_tvalid <= 1'b1;
		s_tdata <= {h, t};
		do @(posedge clk); while (!s_tready);
		expected_readings = {expected_readings, want};
		samples_sent++;
	endtask

	task automatic sender_gap();
		int n;
		n = $urandom_range(1, 7);
		s_tvalid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding",
				cycle_count, expected_readings.size());
			$display("end of test: mismatches");
			$finish;
		end
	end

	always @(posedge clk) begin
		hi_reading_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_readings.size() == 0) begin
				note_mismatch("result with nothing pending", $signed(m_tdata), 0);
			end else begin
				want = expected_readings.pop_front();
				if ($signed(m_tdata) != want.hi)
					note_mismatch("heat_index", $signed(m_tdata), want.hi);
				if (m_tuser[0] != want.sat)
					note_mismatch("saturated", m_tuser[0], want.sat);
				if (want.sat) saturated_seen++;
			end
			results_checked++;
		end
	end

	// Output side: random stall bursts, none once the tail of the run begins.
	initial begin
		int n;
		while (!arst_n) @(posedge clk);
		forever begin
			if (!steady_tail && $urandom_range(0, 2) == 0) begin
				n = $urandom_range(1, 7);
				m_tready <= 1'b0;
				repeat (n) @(posedge clk);
			end
			n = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
			m_tready <= 1'b1;
			repeat (n) @(posedge clk);
		end
	end

	initial begin
		logic signed [12:0] t;
		logic [10:0] h;
		hi_reading_t want;
		int i;
		for (i = 0; i < 16; i++)
			coef_k[i] = scaled_coef(TERM_MANT[i], TERM_DEXP[i], TERM_NEG[i]);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (DIRECTED[i]) begin
			if ($urandom_range(0, 2) == 0) sender_gap();
			if (DIRECTED[i].typed) begin
				want.hi = DIRECTED[i].hi;
				want.sat = DIRECTED[i].sat;
			end else begin
				want = heat_index_of(DIRECTED[i].temp, DIRECTED[i].hum);
			end
			send_sample(DIRECTED[i].temp, DIRECTED[i].hum, want);
		end

		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if (i == RANDOM_ITEMS - STEADY_TAIL) steady_tail = 1'b1;
			if (i == RANDOM_ITEMS / 2) begin
				// Let the pipeline run completely dry before continuing.
				s_tvalid <= 1'b0;
				do @(posedge clk); while (expected_readings.size() != 0);
			end else if (!steady_tail && $urandom_range(0, 3) == 0) begin
				sender_gap();
			end
			case ($urandom_range(0, 9))
				0, 1: begin
					t = 13'($urandom);
					h = 11'($urandom);
				end
				2: begin
					t = 13'(T_EDGES[$urandom_range(0, 5)]);
					h = 11'(H_EDGES[$urandom_range(0, 4)]);
				end
				default: begin
					t = 13'(int'($urandom_range(0, 3200)) - 640);
					h = 11'($urandom_range(0, 1600));
				end
			endcase
			send_sample(t, h, heat_index_of(t, h));
		end
		s_tvalid <= 1'b0;

		while (expected_readings.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d samples sent, %0d results checked, %0d of them saturated",
			samples_sent, results_checked, saturated_seen);
		$display("stimulus: corners, out-of-range inputs, random stalls on both sides");
		if (mismatch_count == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule
